// ===== design/mmp2_pkg.sv =====
// Shared types and constants for the 2x2 modular matrix power block.
// No dependencies; imported by mmp2_modmul and mod_matrix_power_2x2_top.
`timescale 1ns / 1ps
`default_nettype none

package mmp2_pkg;

	localparam int MATRIX_DIM = 2;
	localparam int CELLS      = MATRIX_DIM * MATRIX_DIM;
	localparam int ENTRY_W    = 30;
	localparam int EXP_BITS   = 30;
	// exponent bits that can ever be nonzero at the port
	localparam int EXP_USE    = (EXP_BITS < ENTRY_W) ? EXP_BITS : ENTRY_W;

	localparam logic [ENTRY_W-1:0] PRIME   = 30'd1000000007;
	localparam logic [31:0]        PRIME_X1 = 32'd1000000007;
	localparam logic [31:0]        PRIME_X2 = 32'd2000000014;

	// Barrett reduction for x < 2^(2*ENTRY_W): mu = floor(2^60 / p)
	localparam logic [63:0] MU_WIDE    = 64'h1000_0000_0000_0000 / 64'd1000000007;
	localparam logic [30:0] BARRETT_MU = MU_WIDE[30:0];

	// Tag that rides with each product through the multiplier.
	typedef struct packed {
		logic       sel_sq; // 1: product belongs to square, 0: to accumulator
		logic [1:0] entry;  // destination entry {row, col}
		logic       k;      // which of the two terms of the dot product
	} mmp2_tag_t;

endpackage

`default_nettype wire

// ===== design/mod_matrix_power_2x2_top.sv =====
// Top level: 2x2 matrix power modulo 1000000007 by square-and-multiply.
// Sequencer and matrix registers; depends on mmp2_pkg and mmp2_modmul.
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Handshake             | Payload
// ---------+-----------------------+-----------------------------------------
// input    | start & !busy         | base_r0c0..base_r1c1, exponent (30b each)
// result   | done (one-cycle beat) | power_r0c0..power_r1c1 (30b each)
//
// One multiplier pipeline (4 stages) is shared by every entry product.
// Per exponent bit: a check state, then eight entry products issued for each
// matrix product needed (accumulate and/or square, up to 16), then a wait
// until the multiplier has drained.
// Reset is asynchronous, active low, and returns the block to idle.
// busy is high from the cycle after a start beat until the done beat; the
// result beat cannot be stalled and a new start is taken in that same cycle.

module mod_matrix_power_2x2_top
	import mmp2_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [ENTRY_W-1:0] base_r0c0,
	input  wire logic [ENTRY_W-1:0] base_r0c1,
	input  wire logic [ENTRY_W-1:0] base_r1c0,
	input  wire logic [ENTRY_W-1:0] base_r1c1,
	input  wire logic [ENTRY_W-1:0] exponent,
	output logic                    done,
	output logic [ENTRY_W-1:0]      power_r0c0,
	output logic [ENTRY_W-1:0]      power_r0c1,
	output logic [ENTRY_W-1:0]      power_r1c0,
	output logic [ENTRY_W-1:0]      power_r1c1
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_CHECK,
		S_ISSUE,
		S_WAIT
	} state_t;

	state_t             state_q;
	logic [EXP_USE-1:0] rem_q;
	logic               do_acc_q, do_sq_q;
	logic [3:0]         issue_q, last_q;

	// matrices, row-major {row, col}
	logic [ENTRY_W-1:0] acc_q    [CELLS];
	logic [ENTRY_W-1:0] sq_q     [CELLS];
	logic [ENTRY_W-1:0] acc_nx_q [CELLS];
	logic [ENTRY_W-1:0] sq_nx_q  [CELLS];
	logic [ENTRY_W-1:0] part_q;

	logic               accept;
	logic               rem_zero;
	logic               next_acc, next_sq;

	// multiplier interface
	logic               mul_valid;
	logic [ENTRY_W-1:0] mul_a, mul_b;
	mmp2_tag_t          mul_tag;
	logic               res_valid;
	logic [ENTRY_W-1:0] res_val;
	mmp2_tag_t          res_tag;
	logic               unit_busy;

	// dot-product accumulate
	logic [ENTRY_W:0]   sum;
	logic [ENTRY_W:0]   sum_red;

	assign busy     = (state_q != S_IDLE);
	assign accept   = start && !busy;
	assign rem_zero = (rem_q == '0);
	assign next_acc = rem_q[0];
	assign next_sq  = ((rem_q >> 1) != '0);

	// issue index: [3] matrix (0 acc*sq, 1 sq*sq), [2] row, [1] col, [0] k
	always_comb begin
		mul_valid      = (state_q == S_ISSUE);
		mul_tag.sel_sq = issue_q[3];
		mul_tag.entry  = issue_q[2:1];
		mul_tag.k      = issue_q[0];
		mul_a = issue_q[3] ? sq_q[{issue_q[2], issue_q[0]}]
		                   : acc_q[{issue_q[2], issue_q[0]}];
		mul_b = sq_q[{issue_q[0], issue_q[1]}];
	end

	mmp2_modmul u_modmul (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (mul_valid),
		.in_a      (mul_a),
		.in_b      (mul_b),
		.in_tag    (mul_tag),
		.out_valid (res_valid),
		.out_res   (res_val),
		.out_tag   (res_tag),
		.busy      (unit_busy)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			done     <= 1'b0;
			rem_q    <= '0;
			do_acc_q <= 1'b0;
			do_sq_q  <= 1'b0;
			issue_q  <= '0;
			last_q   <= '0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						rem_q   <= exponent[EXP_USE-1:0];
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (rem_zero) begin
						done    <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						do_acc_q <= next_acc;
						do_sq_q  <= next_sq;
						issue_q  <= next_acc ? 4'd0 : 4'd8;
						last_q   <= next_sq ? 4'd15 : 4'd7;
						rem_q    <= rem_q >> 1;
						state_q  <= S_ISSUE;
					end
				end
				S_ISSUE: begin
					issue_q <= issue_q + 4'd1;
					if (issue_q == last_q) begin
						state_q <= S_WAIT;
					end
				end
				S_WAIT: begin
					if (!unit_busy) begin
						state_q <= S_CHECK;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign sum     = {1'b0, part_q} + {1'b0, res_val};
	assign sum_red = (sum >= {1'b0, PRIME}) ? (sum - {1'b0, PRIME}) : sum;

	// matrix registers and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			acc_q[0] <= 30'd1;
			acc_q[1] <= '0;
			acc_q[2] <= '0;
			acc_q[3] <= 30'd1;
			// entries below 2^30 < 2p need at most one subtract
			sq_q[0] <= (base_r0c0 >= PRIME) ? base_r0c0 - PRIME : base_r0c0;
			sq_q[1] <= (base_r0c1 >= PRIME) ? base_r0c1 - PRIME : base_r0c1;
			sq_q[2] <= (base_r1c0 >= PRIME) ? base_r1c0 - PRIME : base_r1c0;
			sq_q[3] <= (base_r1c1 >= PRIME) ? base_r1c1 - PRIME : base_r1c1;
		end else if (state_q == S_WAIT && !unit_busy) begin
			if (do_acc_q) begin
				acc_q <= acc_nx_q;
			end
			if (do_sq_q) begin
				sq_q <= sq_nx_q;
			end
		end

		// both terms of an entry come out back to back
		if (res_valid) begin
			if (!res_tag.k) begin
				part_q <= res_val;
			end else if (res_tag.sel_sq) begin
				sq_nx_q[res_tag.entry] <= sum_red[ENTRY_W-1:0];
			end else begin
				acc_nx_q[res_tag.entry] <= sum_red[ENTRY_W-1:0];
			end
		end

		if (state_q == S_CHECK && rem_zero) begin
			power_r0c0 <= acc_q[0];
			power_r0c1 <= acc_q[1];
			power_r1c0 <= acc_q[2];
			power_r1c1 <= acc_q[3];
		end
	end

	// a start beat always moves the block out of idle
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("start beat not taken");

	// the multiplier is drained before the block goes idle
	a_idle_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !unit_busy)
		else $error("multiplier busy while idle");

	// a result beat only ends a busy period
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result beat without work");

	// every result entry is a reduced residue
	a_done_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (power_r0c0 < PRIME) && (power_r0c1 < PRIME) &&
		         (power_r1c0 < PRIME) && (power_r1c1 < PRIME))
		else $error("result entry not reduced");

	// products arrive only while the sequencer is issuing or waiting on them
	a_result_window: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (state_q == S_ISSUE) || (state_q == S_WAIT))
		else $error("product outside a matrix step");

endmodule

`default_nettype wire

// ===== design/mmp2_modmul.sv =====
// Pipelined modular multiplier, a*b mod p, one product per cycle.
// Barrett reduction; depends on mmp2_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mmp2_modmul
	import mmp2_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic [ENTRY_W-1:0] in_a,
	input  wire logic [ENTRY_W-1:0] in_b,
	input  wire mmp2_tag_t          in_tag,
	output logic                    out_valid,
	output logic [ENTRY_W-1:0]      out_res,
	output mmp2_tag_t               out_tag,
	output logic                    busy
);

	logic                 valid_s1, valid_s2, valid_s3, valid_s4;
	mmp2_tag_t            tag_s1, tag_s2, tag_s3, tag_s4;
	logic [2*ENTRY_W-1:0] prod_s1;
	logic [61:0]          qprod_s2;
	logic [31:0]          xlo_s2;
	logic [31:0]          r_s3;
	logic [ENTRY_W-1:0]   res_s4;
	logic [32:0]          d1, d2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// r < 3p after Barrett: pick r, r-p or r-2p
	assign d1 = {1'b0, r_s3} - {1'b0, PRIME_X1};
	assign d2 = {1'b0, r_s3} - {1'b0, PRIME_X2};

	always_ff @(posedge clk) begin
		// s1: full product
		prod_s1  <= (2*ENTRY_W)'(in_a) * (2*ENTRY_W)'(in_b);
		tag_s1   <= in_tag;
		// s2: quotient estimate
		qprod_s2 <= 62'(prod_s1[2*ENTRY_W-1:ENTRY_W-1]) * 62'(BARRETT_MU);
		xlo_s2   <= prod_s1[31:0];
		tag_s2   <= tag_s1;
		// s3: remainder, exact modulo 2^32
		r_s3     <= xlo_s2 - (32'(qprod_s2[61:ENTRY_W+1]) * PRIME_X1);
		tag_s3   <= tag_s2;
		// s4: final correction
		if (!d2[32]) begin
			res_s4 <= d2[ENTRY_W-1:0];
		end else if (!d1[32]) begin
			res_s4 <= d1[ENTRY_W-1:0];
		end else begin
			res_s4 <= r_s3[ENTRY_W-1:0];
		end
		tag_s4   <= tag_s3;
	end

	assign out_valid = valid_s4;
	assign out_res   = res_s4;
	assign out_tag   = tag_s4;
	assign busy      = valid_s1 | valid_s2 | valid_s3 | valid_s4;

endmodule

`default_nettype wire
